### hw/rtl/mfp_pkg.sv
// shared types, constants and the crc byte update for the feedback frame parser
package mfp_pkg;

    // frame layout
    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    // header bytes and crc settings
    localparam logic [7:0]  HDR_FIRST  = 8'hFD;
    localparam logic [7:0]  HDR_SECOND = 8'hEE;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    // field masks
    localparam logic [7:0] MASK_ID    = 8'h0F;
    localparam logic [7:0] MASK_MODE  = 8'h07;
    localparam logic [7:0] MASK_ERR   = 8'h07;
    localparam logic [7:0] MASK_FORCE = 8'h7F;
    localparam logic [7:0] MASK_FLOW  = 8'h1F;

    // parser phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    // one unpacked frame
    typedef struct packed {
        logic        [3:0]  motor_id;
        logic        [2:0]  motor_mode;
        logic signed [15:0] torque_raw;
        logic signed [15:0] speed_raw;
        logic signed [31:0] position_raw;
        logic signed [7:0]  temperature;
        logic        [2:0]  error_code;
        logic        [11:0] foot_force;
        logic               crc_ok;
    } t_result;

    // reflected crc-16 update over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc after the two header bytes
    localparam logic [15:0] CRC_AFTER_HDR = crc_byte(crc_byte(CRC_INIT, HDR_FIRST), HDR_SECOND);

endpackage

### hw/rtl/mfp_byte_if.sv
// received byte channel
interface mfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

### hw/rtl/mfp_result_if.sv
// unpacked frame result channel
interface mfp_result_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  motor_id;
    logic        [2:0]  motor_mode;
    logic signed [15:0] torque_raw;
    logic signed [15:0] speed_raw;
    logic signed [31:0] position_raw;
    logic signed [7:0]  temperature;
    logic        [2:0]  error_code;
    logic        [11:0] foot_force;
    logic               crc_ok;

    modport source (output valid, output motor_id, output motor_mode, output torque_raw,
                    output speed_raw, output position_raw, output temperature,
                    output error_code, output foot_force, output crc_ok, input ready);
    modport sink   (input valid, input motor_id, input motor_mode, input torque_raw,
                    input speed_raw, input position_raw, input temperature,
                    input error_code, input foot_force, input crc_ok, output ready);
endinterface

### hw/rtl/mfp_cfg_if.sv
// configuration write channel
interface mfp_cfg_if;
    logic valid;
    logic ready;
    logic drop_bad_crc;

    modport source (output valid, output drop_bad_crc, input ready);
    modport sink   (input valid, input drop_bad_crc, output ready);
endinterface

### hw/rtl/mfp_collector.sv
// header hunt, frame byte store, running crc and frame-end unpacking
module mfp_collector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_restart,
    input  logic                 i_drop_bad_crc,
    output logic                 o_last_pending,
    output logic                 o_emit,
    output mfp_pkg::t_result     o_result
);

    localparam logic [mfp_pkg::POS_W-1:0] CRC_END_POS = mfp_pkg::POS_W'(mfp_pkg::FRAME_BYTES - 2);
    localparam logic [mfp_pkg::POS_W-1:0] LAST_POS    = mfp_pkg::POS_W'(mfp_pkg::FRAME_BYTES - 1);
    localparam logic [mfp_pkg::POS_W-1:0] FIRST_BODY  = mfp_pkg::POS_W'(2);

    mfp_pkg::t_phase              r_phase, n_phase;
    logic [mfp_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [15:0]                  r_crc, n_crc;
    logic [7:0]                   r_store [mfp_pkg::FRAME_BYTES];

    mfp_pkg::t_phase              w_phase_eff;
    logic [mfp_pkg::POS_W-1:0]    w_pos_eff;
    logic                         w_hdr_wr;
    logic                         w_body_wr;
    logic                         w_frame_end;
    logic                         w_crc_ok;
    logic [7:0]                   w_b12;
    logic [7:0]                   w_b13;

    // restart abandons the partial frame before this byte
    assign w_phase_eff = i_restart ? mfp_pkg::PH_HUNT : r_phase;
    assign w_pos_eff   = i_restart ? '0 : r_pos;

    // next state
    always_comb begin
        n_phase   = w_phase_eff;
        n_pos     = w_pos_eff;
        n_crc     = r_crc;
        w_hdr_wr  = 1'b0;
        w_body_wr = 1'b0;
        case (w_phase_eff)
            mfp_pkg::PH_SECOND: begin
                if (i_rx_byte == mfp_pkg::HDR_SECOND) begin
                    w_hdr_wr = 1'b1;
                    n_crc    = mfp_pkg::CRC_AFTER_HDR;
                    n_pos    = FIRST_BODY;
                    n_phase  = mfp_pkg::PH_COLLECT;
                end else if (i_rx_byte != mfp_pkg::HDR_FIRST) begin
                    n_phase = mfp_pkg::PH_HUNT;
                end
            end
            mfp_pkg::PH_COLLECT: begin
                w_body_wr = 1'b1;
                if (w_pos_eff < CRC_END_POS) begin
                    n_crc = mfp_pkg::crc_byte(r_crc, i_rx_byte);
                end
                if (w_pos_eff != LAST_POS) begin
                    n_pos = mfp_pkg::POS_W'(w_pos_eff + 1'b1);
                end else begin
                    n_pos   = '0;
                    n_phase = mfp_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = (i_rx_byte == mfp_pkg::HDR_FIRST) ? mfp_pkg::PH_SECOND
                                                            : mfp_pkg::PH_HUNT;
                n_pos   = '0;
            end
        endcase
    end

    // outputs: frame end check and field unpacking
    always_comb begin
        w_b12       = r_store[12];
        w_b13       = r_store[13];
        w_frame_end = (w_phase_eff == mfp_pkg::PH_COLLECT) && (w_pos_eff == LAST_POS);
        w_crc_ok    = ({i_rx_byte, r_store[CRC_END_POS]} == r_crc);
        o_emit      = i_accept && w_frame_end && (w_crc_ok || !i_drop_bad_crc);
        o_last_pending = (r_phase == mfp_pkg::PH_COLLECT) && (r_pos == LAST_POS);

        o_result.motor_id     = 4'(r_store[2] & mfp_pkg::MASK_ID);
        o_result.motor_mode   = 3'((r_store[2] >> 4) & mfp_pkg::MASK_MODE);
        o_result.torque_raw   = {r_store[4], r_store[3]};
        o_result.speed_raw    = {r_store[6], r_store[5]};
        o_result.position_raw = {r_store[10], r_store[9], r_store[8], r_store[7]};
        o_result.temperature  = r_store[11];
        o_result.error_code   = 3'(w_b12 & mfp_pkg::MASK_ERR);
        o_result.foot_force   = {7'(w_b13 & mfp_pkg::MASK_FORCE),
                                 5'((w_b12 >> 3) & mfp_pkg::MASK_FLOW)};
        o_result.crc_ok       = w_crc_ok;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mfp_pkg::PH_HUNT;
            r_pos   <= '0;
            r_crc   <= mfp_pkg::CRC_INIT;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
        end
    end

    // frame byte store
    always_ff @(posedge i_clk) begin
        if (i_accept && w_hdr_wr) begin
            r_store[0] <= mfp_pkg::HDR_FIRST;
            r_store[1] <= mfp_pkg::HDR_SECOND;
        end
        if (i_accept && w_body_wr) begin
            r_store[w_pos_eff] <= i_rx_byte;
        end
    end

endmodule

### hw/rtl/motor_feedback_frame_parser_unit.sv
// top level of the motor feedback frame parser
// Takes one received byte per cycle while the input is not stalled, hunts
// for the 0xFD 0xEE header and collects a 16-byte frame while a byte-wide
// reflected CRC-16 (poly 0x8408, init 0) runs over bytes 0 to 13. The
// unpacked fields are registered into the result register as the frame's
// last byte is accepted; with drop_bad_crc set, frames failing the CRC give
// no result. Throughput is one byte per cycle outside stalls, as the
// collector updates the crc combinationally for each byte. The byte input
// stalls only when a result is still held and the parser is waiting for
// the last byte of another frame. restart drops any partial frame before its byte.
module motor_feedback_frame_parser_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mfp_byte_if.sink     i_in,
    mfp_cfg_if.sink      i_cfg,
    mfp_result_if.source o_out
);

    logic              r_drop_bad_crc;
    logic              r_out_valid;
    mfp_pkg::t_result  r_out;

    logic              w_accept;
    logic              w_last_pending;
    logic              w_emit;
    mfp_pkg::t_result  w_result;

    // input request accepted unless a held result would be overwritten
    assign i_in.ready = !(r_out_valid && !o_out.ready && w_last_pending);
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    mfp_collector u_collector (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_in.rx_byte),
        .i_restart      (i_in.restart),
        .i_drop_bad_crc (r_drop_bad_crc),
        .o_last_pending (w_last_pending),
        .o_emit         (w_emit),
        .o_result       (w_result)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_bad_crc <= 1'b0;
        end else if (i_cfg.valid) begin
            r_drop_bad_crc <= i_cfg.drop_bad_crc;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    // result channel drive
    assign o_out.valid        = r_out_valid;
    assign o_out.motor_id     = r_out.motor_id;
    assign o_out.motor_mode   = r_out.motor_mode;
    assign o_out.torque_raw   = r_out.torque_raw;
    assign o_out.speed_raw    = r_out.speed_raw;
    assign o_out.position_raw = r_out.position_raw;
    assign o_out.temperature  = r_out.temperature;
    assign o_out.error_code   = r_out.error_code;
    assign o_out.foot_force   = r_out.foot_force;
    assign o_out.crc_ok       = r_out.crc_ok;

endmodule
